### src/link_health_monitor_assert.svh
// assertion macros shared by the link health monitor modules
`ifndef LINK_HEALTH_MONITOR_ASSERT_SVH
`define LINK_HEALTH_MONITOR_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LHM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define LHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lhm_pkg.sv
// types and constants of the link health monitor
`timescale 1ns / 1ps
package lhm_pkg;

  localparam int unsigned PERCENT_SCALE = 100;
  localparam int unsigned PCT_W         = 7;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned TIMEOUT_W     = 16;
  localparam int unsigned THRESH_W      = 8;
  localparam int unsigned RUN_W         = 8;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd500;
  localparam logic [THRESH_W-1:0]  THRESH_RST  = 8'd20;
  localparam logic [RUN_W-1:0]     RUN_MAX     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT   = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              req_type;
    logic              frame_present;
    logic              frame_ok;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] health_percent;
    logic             sensor_fault;
    logic             frame_error;
    logic             frame_accepted;
  } out_item_t;

endpackage

### src/lhm_cell.sv
// one window cell: holds one entry and hands it to the next cell on a shift
`timescale 1ns / 1ps
module lhm_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic bit_i,
  output logic bit_o
);

  logic bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (shift_i) begin
      bit_q <= bit_i;
    end
  end

  assign bit_o = bit_q;

endmodule

### src/lhm_window.sv
// row of window cells with running count of ones and percent lookup
`timescale 1ns / 1ps
`include "link_health_monitor_assert.svh"
module lhm_window
  import lhm_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             bit_i,
  output logic [PCT_W-1:0] pct_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);

  logic [WINDOW_SIZE-1:0] win;
  logic [CNT_W-1:0]       ones_q;
  logic [CNT_W-1:0]       ones_d;
  logic [PCT_W-1:0]       pct_lut [WINDOW_SIZE+1];

  for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_cell
    if (k == 0) begin : g_head
      lhm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_i),
        .bit_i   (bit_i),
        .bit_o   (win[k])
      );
    end else begin : g_body
      lhm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_i),
        .bit_i   (win[k-1]),
        .bit_o   (win[k])
      );
    end
  end

  for (genvar k = 0; k <= WINDOW_SIZE; k++) begin : g_lut
    assign pct_lut[k] = PCT_W'((k * PERCENT_SCALE) / WINDOW_SIZE);
  end

  // oldest entry drops out of the tail as the new one enters the head
  always_comb begin
    ones_d = ones_q;
    if (shift_i) begin
      ones_d = ones_q - CNT_W'(win[WINDOW_SIZE-1]) + CNT_W'(bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ones_q <= '0;
    end else begin
      ones_q <= ones_d;
    end
  end

  assign pct_o = pct_lut[ones_d];

  `LHM_ASSERT(a_count_match, 1'b1, ones_q == CNT_W'($countones(win)), "window count mismatch")
  `LHM_ASSERT(a_count_range, 1'b1, ones_q <= CNT_W'(WINDOW_SIZE), "window count out of range")
  `LHM_ASSERT_NXT(a_hold, !shift_i, $stable(win) && $stable(ones_q), "window moved without shift")

endmodule

### src/link_health_monitor.sv
// Link health monitor: takes one poll item per clock cycle and gives its
// result item the cycle after acceptance from an output register. The whole
// update (timeout compare, error run, one shift of the window cell row and
// the running count) completes in the accepting cycle, so sustained rate is
// one item per cycle; in_stall_o rises only while the output register holds
// an item that the far side stalls. Configuration writes are always ready.
`timescale 1ns / 1ps
`include "link_health_monitor_assert.svh"
module link_health_monitor
  import lhm_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [THRESH_W-1:0]  thresh_q;
  logic [RUN_W-1:0]     run_q;
  logic [RUN_W-1:0]     run_d;
  logic [RUN_W-1:0]     run_upd;
  logic [TIME_W-1:0]    last_q;
  logic [TIME_W-1:0]    last_d;
  logic [TIME_W-1:0]    elapsed;
  logic                 accept;
  logic                 poll;
  logic                 good;
  logic                 bad;
  logic                 timed_out;
  logic                 shift;
  logic                 fault;
  logic [PCT_W-1:0]     pct_next;
  logic                 out_valid_q;
  out_item_t            out_item_q;
  cfg_reg_e             cfg_reg;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = cfg_reg_e'(cfg_index_i);

  assign poll      = !in_item_i.req_type;
  assign good      = poll && in_item_i.frame_present && in_item_i.frame_ok;
  assign bad       = poll && in_item_i.frame_present && !in_item_i.frame_ok;
  assign elapsed   = in_item_i.now_ms - last_q;
  assign timed_out = (last_q != '0) && (elapsed >= TIME_W'(timeout_q));
  assign shift     = accept && poll && (in_item_i.frame_present || timed_out);

  always_comb begin
    run_upd = run_q;
    if (good) begin
      run_upd = '0;
    end else if (bad && run_q != RUN_MAX) begin
      run_upd = run_q + RUN_W'(1);
    end
    fault  = poll && (run_upd >= thresh_q);
    run_d  = (!poll || fault) ? '0 : run_upd;
    last_d = good ? in_item_i.now_ms : last_q;
  end

  lhm_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .bit_i   (good),
    .pct_o   (pct_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      thresh_q  <= THRESH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg)
        REG_TIMEOUT:   timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        REG_THRESHOLD: thresh_q  <= cfg_data_i[THRESH_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      last_q <= '0;
    end else if (accept) begin
      run_q  <= run_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q.health_percent <= pct_next;
      out_item_q.sensor_fault   <= fault;
      out_item_q.frame_error    <= bad;
      out_item_q.frame_accepted <= good;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `LHM_ASSERT_NXT(a_fault_clears, accept && fault, run_q == '0, "run not cleared after fault")
  `LHM_ASSERT_NXT(a_source_clears, accept && !poll, run_q == '0, "run not cleared on source change")
  `LHM_ASSERT(a_flags_excl, out_valid_q,
              !(out_item_q.frame_error && out_item_q.frame_accepted), "frame both good and bad")

endmodule

### tb/link_health_monitor_tb.sv
// self-checking testbench of the link health monitor: directed and random polls, scoreboard
`timescale 1ns / 1ps
module link_health_monitor_tb;
  import lhm_pkg::*;

  localparam int unsigned WINDOW_SIZE = 20;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 130;

  class health_scoreboard;
    bit                  window_bits[WINDOW_SIZE];
    int unsigned         ones_cnt;
    int unsigned         slot;
    bit [RUN_W-1:0]      run_len;
    bit [TIME_W-1:0]     last_good;
    bit [TIMEOUT_W-1:0]  timeout;
    bit [THRESH_W-1:0]   threshold;
    out_item_t           health_q[$];
    int unsigned         n_items, n_results, n_faults, n_errs, n_acc, n_bad;

    function new();
      timeout   = TIMEOUT_RST;
      threshold = THRESH_RST;
      foreach (window_bits[i]) window_bits[i] = 1'b0;
      ones_cnt  = 0;
      slot      = 0;
      run_len   = '0;
      last_good = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TIMEOUT:   timeout = data[TIMEOUT_W-1:0];
        REG_THRESHOLD: threshold = data[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_bit(bit b);
      ones_cnt = ones_cnt - window_bits[slot] + b;
      window_bits[slot] = b;
      slot = (slot == WINDOW_SIZE - 1) ? 0 : slot + 1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t       r;
      bit [TIME_W-1:0] elapsed;
      r = '0;
      n_items++;
      if (it.req_type) begin
        run_len = '0;
      end else begin
        if (it.frame_present) begin
          if (it.frame_ok) begin
            push_bit(1'b1);
            run_len = '0;
            last_good = it.now_ms;
            r.frame_accepted = 1'b1;
          end else begin
            push_bit(1'b0);
            if (run_len != RUN_MAX) run_len++;
            r.frame_error = 1'b1;
          end
        end else begin
          elapsed = it.now_ms - last_good;
          if (last_good != '0 && elapsed >= {16'd0, timeout}) push_bit(1'b0);
        end
        if (run_len >= threshold) begin
          r.sensor_fault = 1'b1;
          run_len = '0;
        end
      end
      r.health_percent = PCT_W'((ones_cnt * PERCENT_SCALE) / WINDOW_SIZE);
      health_q.push_back(r);
    endfunction

    function int unsigned pending();
      return health_q.size();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (got.sensor_fault === 1'b1) n_faults++;
      if (got.frame_error === 1'b1) n_errs++;
      if (got.frame_accepted === 1'b1) n_acc++;
      if (health_q.size() == 0) begin
        $display("%0t: result with none expected: pct %0d fault %b err %b acc %b", $time,
                 got.health_percent, got.sensor_fault, got.frame_error, got.frame_accepted);
        n_bad++;
        return;
      end
      want = health_q.pop_front();
      if (got.health_percent !== want.health_percent || got.sensor_fault !== want.sensor_fault
          || got.frame_error !== want.frame_error
          || got.frame_accepted !== want.frame_accepted) begin
        $display("%0t: want pct %0d fault %b err %b acc %b, got pct %0d fault %b err %b acc %b",
                 $time, want.health_percent, want.sensor_fault, want.frame_error,
                 want.frame_accepted, got.health_percent, got.sensor_fault, got.frame_error,
                 got.frame_accepted);
        n_bad++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  health_scoreboard      sb;
  int unsigned           gap_pct;
  int unsigned           stall_pct;
  logic [TIME_W-1:0]     now_t;
  bit                    bad_streak;
  int unsigned           n_settings;

  link_health_monitor #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_input(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_e'(cfg_index), cfg_data);
    end
  end

  function automatic in_item_t mk_poll(logic req, logic pres, logic ok, logic [TIME_W-1:0] t);
    in_item_t it;
    it.req_type      = req;
    it.frame_present = pres;
    it.frame_ok      = ok;
    it.now_ms        = t;
    return it;
  endfunction

  function automatic in_item_t rand_poll();
    logic [TIME_W-1:0] tmo;
    logic [TIME_W-1:0] delta;
    int unsigned       pick;
    tmo  = {16'd0, sb.timeout};
    pick = $urandom_range(99);
    if (pick < 5) begin
      return mk_poll(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
    end
    if (pick < 15) begin
      return mk_poll(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
    end
    if ($urandom_range(99) < 8) bad_streak = ~bad_streak;
    case ($urandom_range(4))
      0: delta = $urandom_range(3);
      1: delta = $urandom_range(0, tmo);
      2: delta = tmo - 1;
      3: delta = tmo;
      default: delta = $urandom;
    endcase
    now_t = now_t + delta;
    return mk_poll(1'b0, ($urandom_range(99) < 55),
                   bad_streak ? ($urandom_range(99) < 10) : ($urandom_range(99) < 95), now_t);
  endfunction

  task automatic send_poll(in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg_port(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic set_limits(logic [TIMEOUT_W-1:0] tmo, logic [THRESH_W-1:0] thr);
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    write_reg_port(REG_TIMEOUT, tmo);
    write_reg_port(REG_THRESHOLD, {junk, thr});
    n_settings++;
  endtask

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [TIMEOUT_W-1:0] tmo;
    logic [THRESH_W-1:0]  thr;
    sb         = new();
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    gap_pct    = 0;
    stall_pct  = 0;
    now_t      = 32'd5000;
    bad_streak = 1'b0;
    n_settings = 1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed polls at reset limits
    send_poll(mk_poll(1'b0, 1'b0, 1'b0, 32'd0));
    send_poll(mk_poll(1'b0, 1'b0, 1'b1, 32'd1000));
    send_poll(mk_poll(1'b0, 1'b1, 1'b1, 32'd0));
    send_poll(mk_poll(1'b0, 1'b0, 1'b0, 32'd100000));
    send_poll(mk_poll(1'b0, 1'b1, 1'b1, 32'd1000));
    send_poll(mk_poll(1'b0, 1'b0, 1'b0, 32'd1499));
    send_poll(mk_poll(1'b0, 1'b0, 1'b0, 32'd1500));
    send_poll(mk_poll(1'b0, 1'b1, 1'b0, 32'd1600));
    send_poll(mk_poll(1'b0, 1'b1, 1'b0, 32'd1601));
    send_poll(mk_poll(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_poll(mk_poll(1'b0, 1'b1, 1'b1, 32'hFFFF_FFF0));
    send_poll(mk_poll(1'b0, 1'b0, 1'b0, 32'h0000_01E3));
    send_poll(mk_poll(1'b0, 1'b0, 1'b0, 32'h0000_01E4));
    send_poll(mk_poll(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_poll(mk_poll(1'b1, 1'b0, 1'b0, 32'd0));
    send_poll(mk_poll(1'b0, 1'b1, 1'b0, 32'h5555_AAAA));
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin tmo = 16'd0;     thr = 8'd0;   end
        1: begin tmo = 16'd1;     thr = 8'd1;   end
        2: begin tmo = 16'hFFFF;  thr = 8'd255; end
        3: begin tmo = 16'd300;   thr = 8'd3;   end
        4: begin
          tmo = TIMEOUT_W'($urandom_range(1, 2000));
          thr = THRESH_W'($urandom_range(1, 30));
        end
        5: begin tmo = 16'd20;    thr = 8'd8;   end
        6: begin
          tmo = TIMEOUT_W'($urandom);
          thr = THRESH_W'($urandom_range(1, 40));
        end
        default: begin tmo = TIMEOUT_RST; thr = THRESH_RST; end
      endcase
      set_limits(tmo, thr);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 56; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 56; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_poll(rand_poll());
      drain();
      stall_pct = 0;
    end

    $display("run covered %0d items and %0d results over %0d limit settings", sb.n_items,
             sb.n_results, n_settings);
    $display("results held %0d fault pulses, %0d frame errors, %0d accepted frames",
             sb.n_faults, sb.n_errs, sb.n_acc);
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/lhm_pkg.sv
src/lhm_cell.sv
src/lhm_window.sv
src/link_health_monitor.sv
tb/link_health_monitor_tb.sv
